/* design/touch_point_scan_filter_core_macros.svh */
// Assertion macros shared by the checker.
`ifndef TOUCH_POINT_SCAN_FILTER_CORE_MACROS_SVH
`define TOUCH_POINT_SCAN_FILTER_CORE_MACROS_SVH

// Consequence checked in the same cycle as the antecedent.
`define TPSF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define TPSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/tpsf_pkg.sv */
`timescale 1ns / 1ps

package tpsf_pkg;

    localparam int STORE_DEPTH = 5;
    localparam int SAVE_SLOT   = 4;

    localparam logic [7:0]  ST_READY     = 8'h80;
    localparam logic [7:0]  MODE_MASK    = 8'h8F;
    localparam logic [7:0]  KEEP_MASK    = 8'hE0;
    localparam logic [7:0]  DOWN_CAUGHT  = 8'hC0;
    localparam logic [15:0] POINT_NONE   = 16'hFFFF;
    localparam logic [7:0]  CNT_WRAP     = 8'd240;
    localparam logic [7:0]  CNT_RELOAD   = 8'd10;
    localparam logic [7:0]  SAMPLE_EVERY = 8'd10;

    localparam logic [15:0] RST_WIDTH  = 16'd480;
    localparam logic [15:0] RST_HEIGHT = 16'd800;
    localparam logic [15:0] RST_MIRROR = 16'd800;

    typedef enum logic [7:0] {
        CFG_LANDSCAPE = 8'd0,
        CFG_WIDTH     = 8'd1,
        CFG_HEIGHT    = 8'd2,
        CFG_MIRROR    = 8'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  status_byte;
        logic [15:0] p0_word_a;
        logic [15:0] p1_word_a;
        logic [15:0] p2_word_a;
        logic [15:0] p3_word_a;
        logic [15:0] p4_word_a;
        logic [15:0] p0_word_b;
        logic [15:0] p1_word_b;
        logic [15:0] p2_word_b;
        logic [15:0] p3_word_b;
        logic [15:0] p4_word_b;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  slot_index;
        logic [15:0] point_x;
        logic [15:0] point_y;
        logic [7:0]  touch_status;
        logic        touched;
        logic        sampled;
        logic        clear_request;
        logic        last;
    } t_out_beat;

    typedef struct packed {
        logic        landscape;
        logic [15:0] screen_width;
        logic [15:0] screen_height;
        logic [15:0] mirror_span;
    } t_cfg;

    typedef struct packed {
        logic        wr;
        logic [15:0] x;
        logic [15:0] y;
    } t_lane_res;

    typedef struct packed {
        logic [7:0]                        counter;
        logic [7:0]                        status;
        logic [STORE_DEPTH-1:0][15:0]      x;
        logic [STORE_DEPTH-1:0][15:0]      y;
    } t_state;

    typedef struct packed {
        logic [7:0] status;
        logic       touched;
        logic       sampled;
        logic       clear_request;
    } t_flags;

    typedef struct packed {
        logic busy;
        logic done;
    } t_ob_stat;

    // Remainder by ten through a reciprocal, exact for all eight-bit values.
    function automatic logic is_mult10(logic [7:0] v);
        logic [15:0] prod;
        logic [4:0]  quot;
        logic [7:0]  rem;
        prod = 16'(v) * 16'd205;
        quot = prod[15:11];
        rem  = v - 8'(quot) * SAMPLE_EVERY;
        return rem == 8'd0;
    endfunction

    function automatic logic [15:0] word_a(t_in_beat d, logic [2:0] idx);
        case (idx)
            3'd0:    return d.p0_word_a;
            3'd1:    return d.p1_word_a;
            3'd2:    return d.p2_word_a;
            3'd3:    return d.p3_word_a;
            default: return d.p4_word_a;
        endcase
    endfunction

    function automatic logic [15:0] word_b(t_in_beat d, logic [2:0] idx);
        case (idx)
            3'd0:    return d.p0_word_b;
            3'd1:    return d.p1_word_b;
            3'd2:    return d.p2_word_b;
            3'd3:    return d.p3_word_b;
            default: return d.p4_word_b;
        endcase
    endfunction

endpackage

/* design/tpsf_lane.sv */
`timescale 1ns / 1ps

module tpsf_lane #(
    parameter int LANE = 0
) (
    input  logic [15:0]        i_word_a,
    input  logic [15:0]        i_word_b,
    input  logic [3:0]         i_point_cnt,
    input  tpsf_pkg::t_cfg     i_cfg,
    output tpsf_pkg::t_lane_res o_res
);
    import tpsf_pkg::*;

    always_comb begin
        o_res.wr = 4'(LANE) < i_point_cnt;
        if (i_cfg.landscape) begin
            o_res.x = i_cfg.mirror_span - i_word_b;
            o_res.y = i_word_a;
        end else begin
            o_res.x = i_word_a;
            o_res.y = i_word_b;
        end
    end

endmodule

/* design/tpsf_merge.sv */
`timescale 1ns / 1ps

module tpsf_merge #(
    parameter int MAX_POINTS = 5
) (
    input  tpsf_pkg::t_in_beat                  i_item,
    input  tpsf_pkg::t_cfg                      i_cfg,
    input  tpsf_pkg::t_state                    i_state,
    input  tpsf_pkg::t_lane_res [MAX_POINTS-1:0] i_lanes,
    output tpsf_pkg::t_state                    o_next,
    output tpsf_pkg::t_flags                    o_flags
);
    import tpsf_pkg::*;

    logic [7:0] cnt_inc;
    logic       sampled;
    logic [3:0] pcnt;
    logic       in_range;
    logic       load;
    logic       off_screen;
    logic [7:0] mode;
    logic [4:0] mask;
    t_state     nxt;

    always_comb begin
        cnt_inc  = i_state.counter + 8'd1;
        sampled  = (cnt_inc < SAMPLE_EVERY) || is_mult10(cnt_inc);
        pcnt     = i_item.status_byte[3:0];
        in_range = (pcnt != 4'd0) && (pcnt <= 4'(MAX_POINTS));
        load     = sampled && in_range;
        mode     = i_item.status_byte;
        mask     = '0;
        for (int j = 0; j < MAX_POINTS; j++) begin
            mask[j] = i_lanes[j].wr;
        end

        nxt         = i_state;
        nxt.counter = cnt_inc;
        off_screen  = 1'b0;

        if (load) begin
            nxt.status       = DOWN_CAUGHT | {3'b000, mask};
            nxt.x[SAVE_SLOT] = i_state.x[0];
            nxt.y[SAVE_SLOT] = i_state.y[0];
            for (int j = 0; j < MAX_POINTS; j++) begin
                if (i_lanes[j].wr) begin
                    nxt.x[j] = i_lanes[j].x;
                    nxt.y[j] = i_lanes[j].y;
                end
            end
            off_screen = (nxt.x[0] > i_cfg.screen_width) || (nxt.y[0] > i_cfg.screen_height);
            if (off_screen) begin
                if (pcnt > 4'd1) begin
                    nxt.x[0]    = nxt.x[1];
                    nxt.y[0]    = nxt.y[1];
                    nxt.counter = '0;
                end else begin
                    nxt.x[0]   = nxt.x[SAVE_SLOT];
                    nxt.y[0]   = nxt.y[SAVE_SLOT];
                    mode       = ST_READY;
                    nxt.status = i_state.status;
                end
            end else begin
                nxt.counter = '0;
            end
        end

        // A ready status with no points releases the touch, or clears slot 0.
        if ((mode & MODE_MASK) == ST_READY) begin
            if (nxt.status[7]) begin
                nxt.status[7] = 1'b0;
            end else begin
                nxt.x[0]   = POINT_NONE;
                nxt.y[0]   = POINT_NONE;
                nxt.status = nxt.status & KEEP_MASK;
            end
        end

        if (nxt.counter > CNT_WRAP) begin
            nxt.counter = CNT_RELOAD;
        end

        o_next                = nxt;
        o_flags.status        = nxt.status;
        o_flags.touched       = load;
        o_flags.sampled       = sampled;
        o_flags.clear_request = sampled && i_item.status_byte[7] && (pcnt <= 4'(MAX_POINTS));
    end

endmodule

/* design/tpsf_out.sv */
`timescale 1ns / 1ps

module tpsf_out #(
    parameter int MAX_POINTS = 5
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_load,
    input  logic [tpsf_pkg::STORE_DEPTH-1:0][15:0]        i_x,
    input  logic [tpsf_pkg::STORE_DEPTH-1:0][15:0]        i_y,
    input  tpsf_pkg::t_flags                              i_flags,
    input  logic                                          i_out_stall,
    output logic                                          o_out_valid,
    output tpsf_pkg::t_out_beat                           o_out_data,
    output tpsf_pkg::t_ob_stat                            o_stat
);
    import tpsf_pkg::*;

    localparam int BEAT_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    logic                          r_busy;
    logic [BEAT_W-1:0]             r_beat;
    logic [MAX_POINTS-1:0][15:0]   r_x;
    logic [MAX_POINTS-1:0][15:0]   r_y;
    t_flags                        r_flags;
    logic                          beat_go;
    logic                          is_last;

    assign is_last     = r_beat == BEAT_W'(MAX_POINTS - 1);
    assign beat_go     = r_busy && !i_out_stall;
    assign o_stat.busy = r_busy;
    assign o_stat.done = beat_go && is_last;
    assign o_out_valid = r_busy;

    always_comb begin
        o_out_data.slot_index    = 3'(r_beat);
        o_out_data.point_x       = r_x[r_beat];
        o_out_data.point_y       = r_y[r_beat];
        o_out_data.touch_status  = r_flags.status;
        o_out_data.touched       = r_flags.touched;
        o_out_data.sampled       = r_flags.sampled;
        o_out_data.clear_request = r_flags.clear_request;
        o_out_data.last          = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_beat <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_beat <= '0;
        end else if (beat_go) begin
            if (is_last) begin
                r_busy <= 1'b0;
                r_beat <= '0;
            end else begin
                r_beat <= r_beat + BEAT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x     <= i_x[MAX_POINTS-1:0];
            r_y     <= i_y[MAX_POINTS-1:0];
            r_flags <= i_flags;
        end
    end

endmodule

/* design/touch_point_scan_filter_core.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Payload
// in        sink       i_in_valid / o_in_stall     i_in_data  (t_in_beat)
// out       source     o_out_valid / i_out_stall   o_out_data (t_out_beat)
// cfg       sink       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One tick is processed in the cycle it is accepted; the lanes and the merge are one
// combinational stage feeding the state registers. Each tick yields MAX_POINTS result
// beats from the output buffer, one per cycle while the output is not stalled.
// A new tick is taken in the cycle the last beat of the previous one leaves.
// Synchronous reset clears the counter, status and stores and loads register defaults.
// A stall on the output holds the current beat; the input stalls while beats remain.

module touch_point_scan_filter_core #(
    parameter int MAX_POINTS = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  tpsf_pkg::t_in_beat   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tpsf_pkg::t_out_beat  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [7:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);
    import tpsf_pkg::*;

    t_cfg                        r_cfg;
    t_state                      r_state;
    t_state                      n_state;
    t_flags                      flags;
    t_lane_res [MAX_POINTS-1:0]  lanes;
    t_ob_stat                    ob_stat;
    logic                        in_go;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = ob_stat.busy && !ob_stat.done;
    assign in_go       = i_in_valid && !o_in_stall;

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_lane
        tpsf_lane #(
            .LANE(g)
        ) u_lane (
            .i_word_a   (word_a(i_in_data, 3'(g))),
            .i_word_b   (word_b(i_in_data, 3'(g))),
            .i_point_cnt(i_in_data.status_byte[3:0]),
            .i_cfg      (r_cfg),
            .o_res      (lanes[g])
        );
    end

    tpsf_merge #(
        .MAX_POINTS(MAX_POINTS)
    ) u_merge (
        .i_item (i_in_data),
        .i_cfg  (r_cfg),
        .i_state(r_state),
        .i_lanes(lanes),
        .o_next (n_state),
        .o_flags(flags)
    );

    tpsf_out #(
        .MAX_POINTS(MAX_POINTS)
    ) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_go),
        .i_x        (n_state.x),
        .i_y        (n_state.y),
        .i_flags    (flags),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .o_stat     (ob_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_go) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.landscape     <= 1'b0;
            r_cfg.screen_width  <= RST_WIDTH;
            r_cfg.screen_height <= RST_HEIGHT;
            r_cfg.mirror_span   <= RST_MIRROR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LANDSCAPE: r_cfg.landscape     <= i_cfg_data[0];
                CFG_WIDTH:     r_cfg.screen_width  <= i_cfg_data;
                CFG_HEIGHT:    r_cfg.screen_height <= i_cfg_data;
                CFG_MIRROR:    r_cfg.mirror_span   <= i_cfg_data;
                default:       ;
            endcase
        end
    end

endmodule

/* design/tpsf_checker.sv */
`timescale 1ns / 1ps

`include "touch_point_scan_filter_core_macros.svh"

module tpsf_checker #(
    parameter int MAX_POINTS = 5
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input tpsf_pkg::t_out_beat  o_out_data
);
    import tpsf_pkg::*;

    logic in_go;
    logic out_go;

    assign in_go  = i_in_valid && !o_in_stall;
    assign out_go = o_out_valid && !i_out_stall;

    `TPSF_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled out beat changed")
    `TPSF_ASSERT_NEXT(a_tick_start, in_go, o_out_valid && (o_out_data.slot_index == 3'd0), "tick did not start at slot 0")
    `TPSF_ASSERT_NEXT(a_slot_step, out_go && !o_out_data.last, o_out_valid && (o_out_data.slot_index == $past(o_out_data.slot_index) + 3'd1), "slot sequence broken")
    `TPSF_ASSERT_NOW(a_last_slot, o_out_valid && o_out_data.last, o_out_data.slot_index == 3'(MAX_POINTS - 1), "last flag on wrong slot")
    `TPSF_ASSERT_NOW(a_stall_busy, o_in_stall, o_out_valid, "input stalled with no beat pending")

endmodule

bind touch_point_scan_filter_core tpsf_checker #(
    .MAX_POINTS(MAX_POINTS)
) u_tpsf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import tpsf_pkg::*;

    localparam int MAX_POINTS     = 5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PRINT_CAP      = 60;

    class touch_scoreboard;
        logic        landscape;
        logic [15:0] scr_width;
        logic [15:0] scr_height;
        logic [15:0] mirror_base;
        logic [7:0]  poll_count;
        logic [7:0]  touch_bits;
        logic [15:0] slot_x[STORE_DEPTH];
        logic [15:0] slot_y[STORE_DEPTH];
        t_out_beat   expected_beats[$];
        int          mismatches;
        int          beats_seen;

        function new();
            landscape   = 1'b0;
            scr_width   = RST_WIDTH;
            scr_height  = RST_HEIGHT;
            mirror_base = RST_MIRROR;
            poll_count  = '0;
            touch_bits  = '0;
            foreach (slot_x[i]) begin
                slot_x[i] = '0;
                slot_y[i] = '0;
            end
            mismatches = 0;
            beats_seen = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [15:0] value);
            case (idx)
                CFG_LANDSCAPE: landscape   = value[0];
                CFG_WIDTH:     scr_width   = value;
                CFG_HEIGHT:    scr_height  = value;
                CFG_MIRROR:    mirror_base = value;
                default: ;
            endcase
        endfunction

        // Works out the five slot beats that one accepted poll tick produces.
        function void note_tick(t_in_beat d);
            logic [15:0] wa[MAX_POINTS];
            logic [15:0] wb[MAX_POINTS];
            logic [7:0]  mode;
            logic [7:0]  saved;
            logic [3:0]  count;
            logic        smp;
            logic        hit;
            logic        clr;
            t_out_beat   beat;
            wa[0] = d.p0_word_a;
            wa[1] = d.p1_word_a;
            wa[2] = d.p2_word_a;
            wa[3] = d.p3_word_a;
            wa[4] = d.p4_word_a;
            wb[0] = d.p0_word_b;
            wb[1] = d.p1_word_b;
            wb[2] = d.p2_word_b;
            wb[3] = d.p3_word_b;
            wb[4] = d.p4_word_b;
            mode  = d.status_byte;
            count = mode[3:0];
            hit   = 1'b0;
            clr   = 1'b0;
            poll_count = poll_count + 8'd1;
            smp = (poll_count % SAMPLE_EVERY == 8'd0) || (poll_count < SAMPLE_EVERY);
            if (smp) begin
                clr = mode[7] && (count <= MAX_POINTS);
                if (count != 4'd0 && count <= MAX_POINTS) begin
                    saved      = touch_bits;
                    touch_bits = DOWN_CAUGHT | 8'((1 << count) - 1);
                    slot_x[SAVE_SLOT] = slot_x[0];
                    slot_y[SAVE_SLOT] = slot_y[0];
                    for (int i = 0; i < MAX_POINTS; i++) begin
                        if (touch_bits[i]) begin
                            if (landscape) begin
                                slot_y[i] = wa[i];
                                slot_x[i] = mirror_base - wb[i];
                            end else begin
                                slot_x[i] = wa[i];
                                slot_y[i] = wb[i];
                            end
                        end
                    end
                    hit = 1'b1;
                    if (slot_x[0] > scr_width || slot_y[0] > scr_height) begin
                        if (count > 4'd1) begin
                            slot_x[0]  = slot_x[1];
                            slot_y[0]  = slot_y[1];
                            poll_count = '0;
                        end else begin
                            slot_x[0]  = slot_x[SAVE_SLOT];
                            slot_y[0]  = slot_y[SAVE_SLOT];
                            mode       = ST_READY;
                            touch_bits = saved;
                        end
                    end else begin
                        poll_count = '0;
                    end
                end
            end
            if ((mode & MODE_MASK) == ST_READY) begin
                if (touch_bits[7]) begin
                    touch_bits[7] = 1'b0;
                end else begin
                    slot_x[0]  = POINT_NONE;
                    slot_y[0]  = POINT_NONE;
                    touch_bits = touch_bits & KEEP_MASK;
                end
            end
            if (poll_count > CNT_WRAP)
                poll_count = CNT_RELOAD;
            for (int i = 0; i < MAX_POINTS; i++) begin
                beat.slot_index    = 3'(i);
                beat.point_x       = slot_x[i];
                beat.point_y       = slot_y[i];
                beat.touch_status  = touch_bits;
                beat.touched       = hit;
                beat.sampled       = smp;
                beat.clear_request = clr;
                beat.last          = (i == MAX_POINTS - 1);
                expected_beats.push_back(beat);
            end
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("MISMATCH %s", msg);
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("beat %0d %s: got %0h, expected %0h",
                                          beats_seen, name, got, want));
        endtask

        task check_beat(t_out_beat got);
            t_out_beat want;
            if (expected_beats.size() == 0) begin
                report_mismatch($sformatf("beat for slot %0d with no tick pending",
                                          got.slot_index));
            end else begin
                want = expected_beats.pop_front();
                compare_field("slot_index", 16'(got.slot_index), 16'(want.slot_index));
                compare_field("point_x", got.point_x, want.point_x);
                compare_field("point_y", got.point_y, want.point_y);
                compare_field("touch_status", 16'(got.touch_status),
                              16'(want.touch_status));
                compare_field("touched", 16'(got.touched), 16'(want.touched));
                compare_field("sampled", 16'(got.sampled), 16'(want.sampled));
                compare_field("clear_request", 16'(got.clear_request),
                              16'(want.clear_request));
                compare_field("last", 16'(got.last), 16'(want.last));
                beats_seen++;
            end
        endtask

        task check_leftover();
            if (expected_beats.size() != 0)
                report_mismatch($sformatf("%0d expected beats never arrived",
                                          expected_beats.size()));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_beat    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_beat   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data  = '0;

    touch_scoreboard sb;
    bit              calm_phase = 1'b0;
    int              stall_left = 0;
    int              idle_cycles = 0;

    touch_point_scan_filter_core #(
        .MAX_POINTS(MAX_POINTS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (calm_phase || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else
            return $urandom_range(20, 4);
    endfunction

    // Result side: check each accepted beat, then decide the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_beat(o_out_data);
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
            if ($urandom_range(3, 0) == 0)
                stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Coordinates mostly land on the current screen; now and then a point is fully random.
    function automatic t_in_beat rand_tick(logic [7:0] st);
        t_in_beat    d;
        logic [15:0] wa[MAX_POINTS];
        logic [15:0] wb[MAX_POINTS];
        logic [15:0] px;
        logic [15:0] py;
        for (int i = 0; i < MAX_POINTS; i++) begin
            if ($urandom_range(7, 0) == 0) begin
                wa[i] = 16'($urandom);
                wb[i] = 16'($urandom);
            end else begin
                px = 16'($urandom_range(sb.scr_width, 0));
                py = 16'($urandom_range(sb.scr_height, 0));
                if (sb.landscape) begin
                    wa[i] = py;
                    wb[i] = sb.mirror_base - px;
                end else begin
                    wa[i] = px;
                    wb[i] = py;
                end
            end
        end
        d.status_byte = st;
        d.p0_word_a   = wa[0];
        d.p1_word_a   = wa[1];
        d.p2_word_a   = wa[2];
        d.p3_word_a   = wa[3];
        d.p4_word_a   = wa[4];
        d.p0_word_b   = wb[0];
        d.p1_word_b   = wb[1];
        d.p2_word_b   = wb[2];
        d.p3_word_b   = wb[3];
        d.p4_word_b   = wb[4];
        return d;
    endfunction

    // A status that never carries a usable point count.
    function automatic logic [7:0] quiet_status();
        logic [7:0] st;
        st = 8'($urandom);
        if (st[3:0] != 4'd0 && st[3:0] <= MAX_POINTS)
            st[3:0] = ($urandom_range(1, 0) == 0) ? 4'd0 : 4'($urandom_range(15, MAX_POINTS + 1));
        return st;
    endfunction

    task automatic send_tick(t_in_beat d);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= d;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        sb.note_tick(d);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(t_cfg_idx idx, logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        sb.set_reg(idx, value);
    endtask

    task automatic write_config(logic land, logic [15:0] w, logic [15:0] h, logic [15:0] m);
        settle();
        put_reg(CFG_LANDSCAPE, {15'd0, land});
        put_reg(CFG_WIDTH, w);
        put_reg(CFG_HEIGHT, h);
        put_reg(CFG_MIRROR, m);
        i_cfg_valid <= 1'b0;
        calm_phase = ($urandom_range(3, 0) == 0);
    endtask

    task automatic run_random(int n_items);
        int r;
        int burst;
        for (int k = 0; k < n_items; k++) begin
            r = $urandom_range(99, 0);
            if (r < 65) begin
                send_tick(rand_tick({1'($urandom), 3'($urandom),
                                     4'($urandom_range(MAX_POINTS, 1))}));
            end else if (r < 75) begin
                send_tick(rand_tick(ST_READY | (8'($urandom) & 8'h70)));
            end else if (r < 85) begin
                burst = $urandom_range(4, 1);
                repeat (burst) send_tick(rand_tick(quiet_status()));
            end else begin
                send_tick(rand_tick(8'($urandom)));
            end
        end
    endtask

    initial begin
        t_in_beat d;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Portrait at the reset sizes: touch, edges, off-screen first point, release.
        d = rand_tick(8'h81);
        d.p0_word_a = 16'd0;
        d.p0_word_b = 16'd0;
        send_tick(d);
        d = rand_tick(8'h85);
        d.p0_word_a = RST_WIDTH;
        d.p0_word_b = RST_HEIGHT;
        d.p3_word_a = 16'd0;
        d.p3_word_b = 16'd0;
        d.p4_word_a = 16'hFFFF;
        d.p4_word_b = 16'hFFFF;
        send_tick(d);
        d = rand_tick(8'h82);
        d.p0_word_a = RST_WIDTH + 16'd1;
        d.p1_word_a = 16'd10;
        d.p1_word_b = 16'd20;
        send_tick(d);
        d = rand_tick(8'h83);
        d.p0_word_a = 16'd0;
        d.p0_word_b = RST_HEIGHT + 16'd1;
        send_tick(d);
        d = rand_tick(8'h01);
        d.p0_word_a = 16'hFFFF;
        d.p0_word_b = 16'hFFFF;
        send_tick(d);
        send_tick(rand_tick(8'h81));
        send_tick(rand_tick(8'h80));
        send_tick(rand_tick(8'h80));
        send_tick(rand_tick(8'h80));
        send_tick(rand_tick(8'h8F));
        send_tick(rand_tick(8'h86));
        send_tick(rand_tick(8'h00));
        send_tick(rand_tick(8'h75));
        send_tick(rand_tick(8'hF3));
        send_tick(rand_tick(8'h7F));

        // A long run without touches walks the poll counter past its wrap point.
        repeat (245) send_tick(rand_tick(quiet_status()));
        run_random(10);

        write_config(1'b1, RST_WIDTH, RST_HEIGHT, RST_MIRROR);
        d = rand_tick(8'h81);
        d.p0_word_a = 16'd800;
        d.p0_word_b = 16'd800;
        send_tick(d);
        d = rand_tick(8'h81);
        d.p0_word_b = 16'hFFFF;
        send_tick(d);
        d = rand_tick(8'h82);
        d.p0_word_b = 16'd0;
        send_tick(d);
        run_random(8);

        write_config(1'b0, 16'd0, 16'd0, 16'd0);
        run_random(8);
        write_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(8);
        write_config(1'b1, 16'd0, 16'd0, 16'd0);
        run_random(6);
        write_config(1'b0, 16'hFFFF, 16'hFFFF, 16'd0);
        run_random(6);
        write_config(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        run_random(6);

        settle();
        sb.check_leftover();
        if (sb.mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
